// ----- rtl/rbst_pkg.sv -----
// Shared types, constants and register codes for the ray/box slab test.
`default_nettype none

package rbst_pkg;

    localparam int DATA_W        = 32;
    localparam int DIFF_W        = DATA_W + 1;
    localparam int PROD_W        = DIFF_W + DATA_W;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    // control stages S1..S6 ahead of the result register
    localparam int PIPE_DEPTH    = 6;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam word_t T_MAX = word_t'({1'b0, {(DATA_W-1){1'b1}}});
    localparam word_t T_MIN = word_t'({1'b1, {(DATA_W-1){1'b0}}});

    localparam word_t ONE_FX = word_t'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X   = 3'd0,
        REG_START_Y   = 3'd1,
        REG_START_Z   = 3'd2,
        REG_INV_DIR_X = 3'd3,
        REG_INV_DIR_Y = 3'd4,
        REG_INV_DIR_Z = 3'd5,
        REG_T_LOWER   = 3'd6,
        REG_T_UPPER   = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        OP_GENERAL  = 1'b0,
        OP_VERTICAL = 1'b1
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
        logic in_box;
    } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/rbst_lane.sv -----
// One axis of the slab test: difference, product, shift/saturate, near/far.
`default_nettype none

module rbst_lane #(
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire rbst_pkg::word_t    box_min,
    input  wire rbst_pkg::word_t    box_max,
    input  wire rbst_pkg::word_t    start,
    input  wire rbst_pkg::word_t    inv,
    output rbst_pkg::word_t         near_t,
    output rbst_pkg::word_t         far_t
);
    import rbst_pkg::*;

    diff_t dmin_reg, dmax_reg, dmin_next, dmax_next;
    prod_t pmin_reg, pmax_reg, pmin_next, pmax_next;
    word_t tmin_reg, tmax_reg, tmin_next, tmax_next;
    word_t near_reg, far_reg, near_next, far_next;

    // floor shift, then clamp to the 32-bit range
    function automatic word_t sat_shift(input prod_t p);
        prod_t                      s;
        logic [PROD_W-DATA_W:0]     top;
        begin
            s   = p >>> FRAC_BITS;
            top = s[PROD_W-1:DATA_W-1];
            if ((&top) || !(|top))
                sat_shift = s[DATA_W-1:0];
            else if (s[PROD_W-1])
                sat_shift = T_MIN;
            else
                sat_shift = T_MAX;
        end
    endfunction

    always_comb
    begin
        dmin_next = diff_t'(box_min) - diff_t'(start);
        dmax_next = diff_t'(box_max) - diff_t'(start);
        pmin_next = prod_t'(dmin_reg) * prod_t'(inv);
        pmax_next = prod_t'(dmax_reg) * prod_t'(inv);
        tmin_next = sat_shift(pmin_reg);
        tmax_next = sat_shift(pmax_reg);
        if (tmin_reg < tmax_reg)
        begin
            near_next = tmin_reg;
            far_next  = tmax_reg;
        end
        else
        begin
            near_next = tmax_reg;
            far_next  = tmin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmin_reg <= dmin_next;
            dmax_reg <= dmax_next;
            pmin_reg <= pmin_next;
            pmax_reg <= pmax_next;
            tmin_reg <= tmin_next;
            tmax_reg <= tmax_next;
            near_reg <= near_next;
            far_reg  <= far_next;
        end
    end

    assign near_t = near_reg;
    assign far_t  = far_reg;

endmodule

`default_nettype wire

// ----- rtl/rbst_span.sv -----
// Interval narrowing: two-level max/min tree over the slab near/far values.
`default_nettype none

module rbst_span (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire rbst_pkg::op_t      op,
    input  wire rbst_pkg::word_t    t_lower,
    input  wire rbst_pkg::word_t    t_upper,
    input  wire rbst_pkg::word_t    near_x,
    input  wire rbst_pkg::word_t    far_x,
    input  wire rbst_pkg::word_t    near_y,
    input  wire rbst_pkg::word_t    far_y,
    input  wire rbst_pkg::word_t    near_z,
    input  wire rbst_pkg::word_t    far_z,
    output rbst_pkg::word_t         lo,
    output rbst_pkg::word_t         hi
);
    import rbst_pkg::*;

    word_t lo_a_reg, lo_b_reg, hi_a_reg, hi_b_reg;
    word_t lo_a_next, lo_b_next, hi_a_next, hi_b_next;
    word_t lo_reg, hi_reg, lo_next, hi_next;

    always_comb
    begin
        lo_a_next = (near_y > t_lower) ? near_y : t_lower;
        hi_a_next = (far_y < t_upper) ? far_y : t_upper;
        // vertical mode only uses the y slab
        if (op == OP_VERTICAL)
        begin
            lo_b_next = near_y;
            hi_b_next = far_y;
        end
        else
        begin
            lo_b_next = (near_x > near_z) ? near_x : near_z;
            hi_b_next = (far_x < far_z) ? far_x : far_z;
        end
        lo_next = (lo_a_reg > lo_b_reg) ? lo_a_reg : lo_b_reg;
        hi_next = (hi_a_reg < hi_b_reg) ? hi_a_reg : hi_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_a_reg <= lo_a_next;
            lo_b_reg <= lo_b_next;
            hi_a_reg <= hi_a_next;
            hi_b_reg <= hi_b_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

`default_nettype wire

// ----- rtl/ray_box_slab_test_top.sv -----
// Top level of the ray versus axis-aligned box slab test pipeline.
`default_nettype none

// Ray/box slab test. Program the ray once through the configuration port
// (start point, per-axis inverse direction, starting interval [t_lower,
// t_upper], all signed fixed point with FRAC_BITS fraction bits), then
// stream boxes. Each box request gives exactly one result: hit and the entry
// distance, or hit=0 with entry_t at the largest value. op=0 runs the full
// three-slab test; op=1 is the vertical test (start x/z inside the box,
// inclusive, then the y slab only). The pipeline takes one request every
// clock while box_stall is low. Steps: difference, 33x32 multiply,
// shift/saturate, near/far sort, two levels of max/min, then the empty-
// interval compare into the result register. When a result is held by
// res_stall the whole pipeline freezes and box_stall rises in the same
// cycle; nothing is dropped or repeated. cfg_ready is always high; write the
// registers only while no request is in flight.
module ray_box_slab_test_top #(
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rbst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire rbst_pkg::word_t                 cfg_data,
    // box requests
    input  wire logic                            box_valid,
    output logic                                 box_stall,
    input  wire logic                            op,
    input  wire rbst_pkg::word_t                 box_min_x,
    input  wire rbst_pkg::word_t                 box_min_y,
    input  wire rbst_pkg::word_t                 box_min_z,
    input  wire rbst_pkg::word_t                 box_max_x,
    input  wire rbst_pkg::word_t                 box_max_y,
    input  wire rbst_pkg::word_t                 box_max_z,
    // results
    output logic                                 res_valid,
    input  wire logic                            res_stall,
    output logic                                 hit,
    output rbst_pkg::word_t                      entry_t
);
    import rbst_pkg::*;

    // ray registers
    word_t start_x_reg, start_y_reg, start_z_reg;
    word_t inv_x_reg, inv_y_reg, inv_z_reg;
    word_t t_lower_reg, t_upper_reg;

    // control pipeline S1..S6, then the result register
    ctl_t  ctl_reg [PIPE_DEPTH];
    ctl_t  ctl_in;
    logic  en;
    logic  inside_next;
    logic  ok;
    logic  res_valid_reg, hit_reg, hit_next;
    word_t entry_reg, entry_next;

    word_t near_x, far_x, near_y, far_y, near_z, far_z;
    word_t span_lo, span_hi;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_z_reg <= '0;
            inv_x_reg   <= ONE_FX;
            inv_y_reg   <= ONE_FX;
            inv_z_reg   <= ONE_FX;
            t_lower_reg <= '0;
            t_upper_reg <= ONE_FX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_START_X:   start_x_reg <= cfg_data;
                REG_START_Y:   start_y_reg <= cfg_data;
                REG_START_Z:   start_z_reg <= cfg_data;
                REG_INV_DIR_X: inv_x_reg   <= cfg_data;
                REG_INV_DIR_Y: inv_y_reg   <= cfg_data;
                REG_INV_DIR_Z: inv_z_reg   <= cfg_data;
                REG_T_LOWER:   t_lower_reg <= cfg_data;
                REG_T_UPPER:   t_upper_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Whole pipe advances unless a finished result is being held.
    assign en        = !(res_valid_reg && res_stall);
    assign box_stall = !en;

    // vertical mode: start x/z inside the box, bounds inclusive
    assign inside_next = !(start_x_reg > box_max_x || start_x_reg < box_min_x ||
                           start_z_reg > box_max_z || start_z_reg < box_min_z);

    always_comb
    begin
        ctl_in.valid  = box_valid;
        ctl_in.op     = op_t'(op);
        ctl_in.in_box = inside_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .clk     (clk),
        .en      (en),
        .box_min (box_min_x),
        .box_max (box_max_x),
        .start   (start_x_reg),
        .inv     (inv_x_reg),
        .near_t  (near_x),
        .far_t   (far_x)
    );

    rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .clk     (clk),
        .en      (en),
        .box_min (box_min_y),
        .box_max (box_max_y),
        .start   (start_y_reg),
        .inv     (inv_y_reg),
        .near_t  (near_y),
        .far_t   (far_y)
    );

    rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .clk     (clk),
        .en      (en),
        .box_min (box_min_z),
        .box_max (box_max_z),
        .start   (start_z_reg),
        .inv     (inv_z_reg),
        .near_t  (near_z),
        .far_t   (far_z)
    );

    // near/far leave the lanes at S4; op of that request sits in ctl_reg[3]
    rbst_span u_span (
        .clk     (clk),
        .en      (en),
        .op      (ctl_reg[3].op),
        .t_lower (t_lower_reg),
        .t_upper (t_upper_reg),
        .near_x  (near_x),
        .far_x   (far_x),
        .near_y  (near_y),
        .far_y   (far_y),
        .near_z  (near_z),
        .far_z   (far_z),
        .lo      (span_lo),
        .hi      (span_hi)
    );

    // General mode: narrowing never reopens an empty interval, so checking
    // once at the end matches the early-exit test.
    always_comb
    begin
        ok = (span_lo <= span_hi) &&
             (ctl_reg[PIPE_DEPTH-1].op == OP_GENERAL || ctl_reg[PIPE_DEPTH-1].in_box);
        hit_next   = ok;
        entry_next = ok ? span_lo : T_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= ctl_reg[PIPE_DEPTH-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg   <= hit_next;
            entry_reg <= entry_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign hit       = hit_reg;
    assign entry_t   = entry_reg;

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the ray versus axis-aligned box slab test.
`timescale 1ns / 100ps

module tb_top;
    import rbst_pkg::*;

    localparam int FRAC            = FRAC_BITS_DEF;
    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES     = 4 * (PIPE_DEPTH + 1);
    // half-width, in raw Q units, of the region boxes are drawn from around the start
    localparam int SPREAD          = 8 << FRAC;

    // handy Q16.16 values for the directed table
    localparam word_t ZERO   = word_t'(0);
    localparam word_t FX1    = ONE_FX;
    localparam word_t FX2    = word_t'(2 << FRAC);
    localparam word_t FX3    = word_t'(3 << FRAC);
    localparam word_t FX4    = word_t'(4 << FRAC);
    localparam word_t HALF   = word_t'(1 << (FRAC - 1));
    localparam word_t QUART  = word_t'(1 << (FRAC - 2));
    localparam word_t THR_Q  = word_t'(3 << (FRAC - 2));
    localparam word_t NEG1   = -ONE_FX;
    localparam word_t NEG2   = -FX2;
    localparam word_t NEG_H  = -HALF;
    localparam word_t CHK_A  = word_t'(32'h5555_5555);
    localparam word_t CHK_B  = word_t'(32'hAAAA_AAAA);

    typedef struct packed {
        op_t   op;
        word_t min_x;
        word_t min_y;
        word_t min_z;
        word_t max_x;
        word_t max_y;
        word_t max_z;
    } box_req_t;

    typedef struct packed {
        logic  hit;
        word_t entry;
    } hit_result_t;

    // one row of the directed table; known rows carry their answer, others
    // go through the predictor
    typedef struct packed {
        box_req_t    req;
        logic        known;
        hit_result_t want;
    } box_row_t;

    typedef enum {
        RAY_NEAR,
        RAY_HIGH,
        RAY_LOW,
        RAY_EMPTY,
        RAY_WILD
    } ray_kind_t;

    localparam hit_result_t MISS      = '{1'b0, T_MAX};
    localparam hit_result_t NO_ANSWER = '{1'b0, ZERO};

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    word_t                cfg_data  = '0;
    logic                 box_valid = 1'b0;
    logic                 box_stall;
    logic                 op        = 1'b0;
    word_t                box_min_x = '0;
    word_t                box_min_y = '0;
    word_t                box_min_z = '0;
    word_t                box_max_x = '0;
    word_t                box_max_y = '0;
    word_t                box_max_z = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic                 hit;
    word_t                entry_t;

    // ------------------------------------------------------------------
    // Shadow copy of the ray registers, at their reset values
    // ------------------------------------------------------------------
    word_t ray_start [3] = '{ZERO, ZERO, ZERO};
    word_t ray_inv   [3] = '{ONE_FX, ONE_FX, ONE_FX};
    word_t ray_t_lo      = ZERO;
    word_t ray_t_hi      = ONE_FX;

    hit_result_t pending_hits [$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    // percent of cycles in which the box sender / result receiver hold off
    int          send_idle_pct  = 32;
    int          recv_idle_pct  = 56;

    ray_kind_t phase_kind [NUM_PHASES] = '{RAY_NEAR, RAY_HIGH, RAY_EMPTY,
                                           RAY_NEAR, RAY_WILD, RAY_LOW,
                                           RAY_NEAR, RAY_EMPTY, RAY_NEAR};

    // Directed boxes, all run against the reset ray: start at the origin,
    // unit inverse direction on every axis, interval [0, 1.0].
    box_row_t dir_table [19] = '{
        // general: unit cube, entered at the start
        '{'{OP_GENERAL, ZERO, ZERO, ZERO, FX1, FX1, FX1}, 1'b1, '{1'b1, ZERO}},
        // general: entry at one half
        '{'{OP_GENERAL, HALF, HALF, HALF, FX2, FX2, FX2}, 1'b1, '{1'b1, HALF}},
        // general: x slab lies past t_upper
        '{'{OP_GENERAL, FX2, ZERO, ZERO, FX3, FX1, FX1}, 1'b1, MISS},
        // general: widest possible box
        '{'{OP_GENERAL, T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX}, 1'b1, '{1'b1, ZERO}},
        // general: inverted corners on every axis
        '{'{OP_GENERAL, T_MAX, T_MAX, T_MAX, T_MIN, T_MIN, T_MIN}, 1'b0, NO_ANSWER},
        // general: box behind the start
        '{'{OP_GENERAL, NEG1, NEG1, NEG1, NEG_H, NEG_H, NEG_H}, 1'b1, MISS},
        // general: entry set by y, exit by z
        '{'{OP_GENERAL, QUART, HALF, ZERO, FX1, FX1, THR_Q}, 1'b1, '{1'b1, HALF}},
        // general: interval shrinks to a single point at t_upper
        '{'{OP_GENERAL, FX1, ZERO, ZERO, FX2, FX1, FX1}, 1'b1, '{1'b1, FX1}},
        // vertical: start inside x/z, y slab entered at a quarter
        '{'{OP_VERTICAL, NEG1, QUART, NEG1, FX1, FX4, FX1}, 1'b1, '{1'b1, QUART}},
        // vertical: start left of x
        '{'{OP_VERTICAL, FX1, ZERO, NEG1, FX2, FX1, FX1}, 1'b1, MISS},
        // vertical: start above z
        '{'{OP_VERTICAL, NEG1, ZERO, NEG2, FX1, FX1, NEG1}, 1'b1, MISS},
        // vertical: zero-width x/z, inclusive bounds still contain the start
        '{'{OP_VERTICAL, ZERO, ZERO, ZERO, ZERO, FX1, ZERO}, 1'b1, '{1'b1, ZERO}},
        // vertical: inverted x corners fail containment
        '{'{OP_VERTICAL, FX1, ZERO, NEG1, NEG1, FX1, FX1}, 1'b1, MISS},
        // vertical: widest box
        '{'{OP_VERTICAL, T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX}, 1'b1, '{1'b1, ZERO}},
        // vertical: y slab past t_upper
        '{'{OP_VERTICAL, NEG1, FX2, NEG1, FX1, FX3, FX1}, 1'b1, MISS},
        // vertical: inverted y corners are only sorted, not rejected
        '{'{OP_VERTICAL, NEG1, T_MAX, NEG1, FX1, T_MIN, FX1}, 1'b0, NO_ANSWER},
        // general: degenerate point box at the start
        '{'{OP_GENERAL, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO}, 1'b1, '{1'b1, ZERO}},
        // general: checkerboard corners
        '{'{OP_GENERAL, CHK_A, CHK_B, CHK_A, CHK_B, CHK_A, CHK_B}, 1'b0, NO_ANSWER},
        // vertical: x box pinned at the most negative value
        '{'{OP_VERTICAL, T_MIN, ZERO, NEG1, T_MIN, FX1, FX1}, 1'b1, MISS}
    };

    ray_box_slab_test_top #(
        .FRAC_BITS (FRAC)
    ) u_top (
        .*
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Distance to one slab plane: exact difference and product, floor shift,
    // then saturation to 32 bits.
    function automatic longint slab_dist(word_t edge_pos, word_t org, word_t inv);
        longint prod;
        longint q;
        prod = (longint'(edge_pos) - longint'(org)) * longint'(inv);
        q    = prod >>> FRAC;
        if (q > longint'(T_MAX))
            q = longint'(T_MAX);
        if (q < longint'(T_MIN))
            q = longint'(T_MIN);
        return q;
    endfunction

    // Clip [t_in, t_out] against one slab; true while the interval is non-empty.
    function automatic logic narrow_slab(word_t bmin, word_t bmax, word_t org,
                                         word_t inv, inout longint t_in,
                                         inout longint t_out);
        longint t0;
        longint t1;
        t0 = slab_dist(bmin, org, inv);
        t1 = slab_dist(bmax, org, inv);
        if (t0 < t1)
        begin
            if (t0 > t_in)
                t_in = t0;
            if (t1 < t_out)
                t_out = t1;
        end
        else
        begin
            if (t1 > t_in)
                t_in = t1;
            if (t0 < t_out)
                t_out = t0;
        end
        return t_in <= t_out;
    endfunction

    function automatic hit_result_t predict_hit(box_req_t r);
        word_t  lo_c [3];
        word_t  hi_c [3];
        longint t_in;
        longint t_out;
        logic   in_box;
        int     i;
        lo_c  = '{r.min_x, r.min_y, r.min_z};
        hi_c  = '{r.max_x, r.max_y, r.max_z};
        t_in  = longint'(ray_t_lo);
        t_out = longint'(ray_t_hi);
        if (r.op == OP_VERTICAL)
        begin
            // start x/z must sit inside the box, bounds included
            in_box = ray_start[0] >= lo_c[0] && ray_start[0] <= hi_c[0] &&
                     ray_start[2] >= lo_c[2] && ray_start[2] <= hi_c[2];
            if (in_box)
                in_box = narrow_slab(lo_c[1], hi_c[1], ray_start[1], ray_inv[1],
                                     t_in, t_out);
        end
        else
        begin
            in_box = 1'b1;
            for (i = 0; i < 3 && in_box; i++)
                in_box = narrow_slab(lo_c[i], hi_c[i], ray_start[i], ray_inv[i],
                                     t_in, t_out);
        end
        return in_box ? hit_result_t'{1'b1, word_t'(t_in)} : MISS;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // base plus a random offset in [lo_off, hi_off], clamped to 32 bits
    function automatic word_t shifted(word_t base, int lo_off, int hi_off);
        longint v;
        v = longint'(base) + longint'(lo_off) +
            longint'($urandom_range(hi_off - lo_off));
        if (v > longint'(T_MAX))
            v = longint'(T_MAX);
        if (v < longint'(T_MIN))
            v = longint'(T_MIN);
        return word_t'(v);
    endfunction

    // Mostly boxes around the current start (sorted, and for vertical mode
    // straddling start x/z), plus raw noise and deliberately broken boxes.
    function automatic box_req_t rand_box();
        box_req_t r;
        word_t    lo_c [3];
        word_t    hi_c [3];
        word_t    a;
        word_t    b;
        int       pick;
        int       i;
        r.op = $urandom_range(1) ? OP_VERTICAL : OP_GENERAL;
        pick = $urandom_range(99);
        for (i = 0; i < 3; i++)
        begin
            a = shifted(ray_start[i], -SPREAD, SPREAD);
            b = shifted(ray_start[i], -SPREAD, SPREAD);
            lo_c[i] = (a < b) ? a : b;
            hi_c[i] = (a < b) ? b : a;
        end
        if (r.op == OP_VERTICAL)
        begin
            for (i = 0; i < 3; i += 2)
            begin
                lo_c[i] = shifted(ray_start[i], -SPREAD, 0);
                hi_c[i] = shifted(ray_start[i], 0, SPREAD);
            end
        end
        i = $urandom_range(2);
        if (pick < 8)
        begin
            // swapped corners on one axis
            a       = lo_c[i];
            lo_c[i] = hi_c[i];
            hi_c[i] = a;
        end
        else if (pick < 15)
        begin
            // one axis moved wholly past the start
            lo_c[i] = shifted(ray_start[i], 1, SPREAD);
            hi_c[i] = shifted(lo_c[i], 0, SPREAD);
        end
        r.min_x = lo_c[0];
        r.min_y = lo_c[1];
        r.min_z = lo_c[2];
        r.max_x = hi_c[0];
        r.max_y = hi_c[1];
        r.max_z = hi_c[2];
        if (pick >= 85)
        begin
            r.min_x = $urandom();
            r.min_y = $urandom();
            r.min_z = $urandom();
            r.max_x = $urandom();
            r.max_y = $urandom();
            r.max_z = $urandom();
        end
        return r;
    endfunction

    // One register write; keeps the shadow copy in step. Entered and left
    // on a falling edge, cfg_valid left high for a following write.
    task automatic write_reg(cfg_idx_t idx, word_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_START_X:   ray_start[0] = value;
            REG_START_Y:   ray_start[1] = value;
            REG_START_Z:   ray_start[2] = value;
            REG_INV_DIR_X: ray_inv[0]   = value;
            REG_INV_DIR_Y: ray_inv[1]   = value;
            REG_INV_DIR_Z: ray_inv[2]   = value;
            REG_T_LOWER:   ray_t_lo     = value;
            REG_T_UPPER:   ray_t_hi     = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Load a whole ray. The baseline is a modest ray near the origin; the
    // other kinds push it to the corners of the number range.
    task automatic setup_ray(ray_kind_t kind);
        word_t s [3];
        word_t v [3];
        word_t tl;
        word_t tu;
        int    i;
        for (i = 0; i < 3; i++)
        begin
            s[i] = shifted(ZERO, -(4 << FRAC), 4 << FRAC);
            v[i] = word_t'($urandom_range(4 << FRAC, 1 << (FRAC - 2)));
            if ($urandom_range(1))
                v[i] = -v[i];
        end
        tl = shifted(ZERO, -(1 << FRAC), 1 << (FRAC - 1));
        tu = shifted(ZERO, 1 << FRAC, 64 << FRAC);
        case (kind)
            RAY_HIGH:
            begin
                s  = '{T_MAX, T_MAX, T_MAX};
                v  = '{T_MIN, T_MAX, ZERO};
                tl = T_MIN;
                tu = T_MAX;
            end
            RAY_LOW:
            begin
                s  = '{T_MIN, T_MIN, T_MIN};
                v  = '{ZERO, T_MIN, T_MAX};
                tl = T_MIN;
                tu = T_MAX;
            end
            RAY_EMPTY:
            begin
                // lower bound above upper bound: nothing can hit
                tl = shifted(ZERO, 1, 2 << FRAC);
                tu = shifted(ZERO, -(1 << FRAC), 0);
            end
            RAY_WILD:
            begin
                for (i = 0; i < 3; i++)
                begin
                    s[i] = $urandom();
                    v[i] = $urandom();
                end
                tl = $urandom();
                tu = $urandom();
            end
            default: ;
        endcase
        write_reg(REG_START_X, s[0]);
        write_reg(REG_START_Y, s[1]);
        write_reg(REG_START_Z, s[2]);
        write_reg(REG_INV_DIR_X, v[0]);
        write_reg(REG_INV_DIR_Y, v[1]);
        write_reg(REG_INV_DIR_Z, v[2]);
        write_reg(REG_T_LOWER, tl);
        write_reg(REG_T_UPPER, tu);
        cfg_valid <= 1'b0;
    endtask

    // Offer one box request after a random hold-off and wait for it to be
    // taken. Entered and left on a falling edge; box_valid stays high on
    // exit so back-to-back requests need no gap.
    task automatic send_box(box_req_t r, logic known, hit_result_t want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            box_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        box_valid <= 1'b1;
        op        <= r.op;
        box_min_x <= r.min_x;
        box_min_y <= r.min_y;
        box_min_z <= r.min_z;
        box_max_x <= r.max_x;
        box_max_y <= r.max_y;
        box_max_z <= r.max_z;
        do
            @(posedge clk);
        while (box_stall);
        pending_hits.push_back(known ? want : predict_hit(r));
        @(negedge clk);
    endtask

    // Stop sending and let the pipeline empty out completely.
    task automatic drain_results();
        box_valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 1) @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result receiver: random back-pressure, changed on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
        res_stall <= ($urandom_range(99) < recv_idle_pct);

    // ------------------------------------------------------------------
    // Result checker: every taken result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        hit_result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("result with no request pending: hit %0d entry_t %0d",
                       hit, entry_t);
                mismatch_count++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, hit);
                    mismatch_count++;
                end
                if (entry_t !== want.entry)
                begin
                    $error("entry_t: expected %0d, got %0d",
                           $signed(want.entry), entry_t);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any handshake on any channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (box_valid && !box_stall) || (res_valid && !res_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int p;
        int n;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed boxes against the reset ray
        foreach (dir_table[k])
            send_box(dir_table[k].req, dir_table[k].known, dir_table[k].want);

        // random phases, each with its own ray; idling pattern moves from a
        // slow receiver, to a slow sender, to full rate
        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES / 3)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 32;
            end
            else if (p == 2 * NUM_PHASES / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // registers only change with nothing in flight
            drain_results();
            setup_ray(phase_kind[p]);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // now and then hold the sender until every result is back
                if (n == ITEMS_PER_PHASE / 2 && p % 3 == 1)
                    drain_results();
                send_box(rand_box(), 1'b0, NO_ANSWER);
            end
        end
        box_valid <= 1'b0;

        while (pending_hits.size() != 0)
            @(posedge clk);
        // catch any stray result after the last expected one
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
